>>> rtl/core/c8x_pkg.sv
// ----------------------------------------------------------------------------
// c8x_pkg: shared types and constants of the CHIP-8 execute unit
// Holds the item op codes, the result codes, the display commands and the
// control group that the sequencer hands to the shared ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package c8x_pkg;

   localparam int AddrBits = 12;
   localparam int MemBytesDefault = 4096;
   localparam int StackDepthDefault = 16;
   localparam int GlyphBytesDefault = 5;

   localparam logic [1:0] OP_EXEC = 2'd0;
   localparam logic [1:0] OP_LOAD = 2'd1;
   localparam logic [1:0] OP_TICK = 2'd2;

   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_OVERFLOW = 2'd1;
   localparam logic [1:0] ERR_UNDERFLOW = 2'd2;
   localparam logic [1:0] ERR_UNDEFINED = 2'd3;

   localparam logic [1:0] DISP_NONE = 2'd0;
   localparam logic [1:0] DISP_CLEAR = 2'd1;
   localparam logic [1:0] DISP_DRAW = 2'd2;

   localparam logic [0:0] CSR_PROGRAM_START = 1'b0;
   localparam logic [0:0] CSR_FONT_BASE = 1'b1;

   // shared ALU operations
   typedef enum logic [3:0] {
      ALU_PASS_B,
      ALU_OR,
      ALU_AND,
      ALU_XOR,
      ALU_ADD,
      ALU_SUB,
      ALU_SHR,
      ALU_SUBN,
      ALU_SHL,
      ALU_DEC_SAT
   } alu_op_type;

   typedef struct packed {
      alu_op_type op;
      logic [7:0] a;
      logic [7:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [7:0] result;
      logic       flag;
      logic       equal;
   } alu_rsp_type;

endpackage

`default_nettype wire

>>> rtl/core/c8x_alu.sv
// ----------------------------------------------------------------------------
// c8x_alu: shared 8-bit ALU
// One add/subtract/logic/shift unit that the sequencer reuses for the 7xkk,
// 8xyN and compare steps of an instruction and for the timer decrements.
// ----------------------------------------------------------------------------
`default_nettype none

module c8x_alu
   import c8x_pkg::*;
(
   input  wire alu_req_type req,
   output alu_rsp_type      rsp
);

   logic [8:0] sum;

   always_comb begin
      sum = 9'd0;
      rsp.result = 8'd0;
      rsp.flag = 1'b0;
      rsp.equal = (req.a == req.b);
      case (req.op)
         ALU_PASS_B: rsp.result = req.b;
         ALU_OR: rsp.result = req.a | req.b;
         ALU_AND: rsp.result = req.a & req.b;
         ALU_XOR: rsp.result = req.a ^ req.b;
         ALU_ADD: begin
            sum = {1'b0, req.a} + {1'b0, req.b};
            rsp.result = sum[7:0];
            rsp.flag = sum[8];
         end
         ALU_SUB: begin
            rsp.result = req.a - req.b;
            rsp.flag = (req.a >= req.b);
         end
         ALU_SUBN: begin
            rsp.result = req.b - req.a;
            rsp.flag = (req.b >= req.a);
         end
         ALU_SHR: begin
            rsp.result = {1'b0, req.a[7:1]};
            rsp.flag = req.a[0];
         end
         ALU_SHL: begin
            rsp.result = {req.a[6:0], 1'b0};
            rsp.flag = req.a[7];
         end
         ALU_DEC_SAT: rsp.result = (req.a == 8'd0) ? 8'd0 : req.a - 8'd1;
         default: rsp.result = 8'd0;
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/core/chip8_instruction_execute.sv
// ----------------------------------------------------------------------------
// chip8_instruction_execute: CHIP-8 instruction execute unit
// Sequencer around one shared 8-bit ALU, the V register file, the return
// stack and a 4 KiB byte memory.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy then stays high
// until the single result is shown on the rsp_ ports for one cycle with
// rsp_valid. The receiver cannot stall. Most instructions go through the
// execute and done states; a timer tick adds a second ALU state since both
// timers go through the one ALU; BCD makes one memory write per digit
// (single write port); Fx55 and Fx65 go through the bytes in turn, Fx65 with
// a final read state, since memory has one write and one read port. Memory
// is not cleared after reset: bytes that were never written read as anything.
// ----------------------------------------------------------------------------
`default_nettype none

module chip8_instruction_execute
   import c8x_pkg::*;
#(
   parameter int STACK_DEPTH = StackDepthDefault,
   parameter int MEM_BYTES = MemBytesDefault,
   parameter int GLYPH_BYTES = GlyphBytesDefault
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   output logic        busy,
   input  wire  [1:0]  req_op,
   input  wire  [15:0] req_opcode,
   input  wire  [11:0] req_load_addr,
   input  wire  [7:0]  req_load_data,
   input  wire  [15:0] req_keys_down,
   input  wire  [4:0]  req_pressed_key,
   input  wire  [7:0]  req_random_byte,
   output logic        rsp_valid,
   output logic [11:0] rsp_next_pc,
   output logic        rsp_waiting_key,
   output logic        rsp_sound_on,
   output logic [1:0]  rsp_display_cmd,
   output logic [1:0]  rsp_error_code,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [0:0]  csr_index,
   input  wire  [11:0] csr_data
);

   localparam int SpBits = $clog2(STACK_DEPTH + 1);
   localparam int SiBits = $clog2(STACK_DEPTH);
   localparam int MemBits = $clog2(MEM_BYTES);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_TICK2,
      ST_BCD,
      ST_STORE,
      ST_LOAD,
      ST_LOAD_LAST,
      ST_DONE
   } state_type;

   state_type state_ff;
   logic [7:0] v_ff [16];
   logic [11:0] i_ff, pc_ff, font_ff;
   logic [11:0] stack_ff [STACK_DEPTH];
   logic [SpBits-1:0] sp_ff;
   logic [7:0] dt_ff, st_ff;
   logic [7:0] mem_ff [MEM_BYTES];
   logic [7:0] rdata_ff;

   // latched item
   logic [1:0] op_ff;
   logic [15:0] w_ff;
   logic [11:0] laddr_ff;
   logic [7:0] ldata_ff;
   logic [15:0] keys_ff;
   logic [4:0] pk_ff;
   logic [7:0] rnd_ff;
   logic [3:0] cnt_ff;
   logic [1:0] bcd_ff;
   logic [7:0] bcd_val_ff;

   logic [11:0] out_pc_ff;
   logic out_wait_ff, out_valid_ff;
   logic [1:0] out_disp_ff, out_err_ff;

   alu_req_type alu_req;
   alu_rsp_type alu_rsp;

   c8x_alu u_alu (.req(alu_req), .rsp(alu_rsp));

   logic [3:0] x, y, n;
   logic [7:0] kk, vx, vy;
   logic [11:0] nnn;
   assign x = w_ff[11:8];
   assign y = w_ff[7:4];
   assign n = w_ff[3:0];
   assign kk = w_ff[7:0];
   assign nnn = w_ff[11:0];
   assign vx = v_ff[x];
   assign vy = v_ff[y];

   assign busy = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE) && !start;
   assign rsp_valid = out_valid_ff;
   assign rsp_next_pc = out_pc_ff;
   assign rsp_waiting_key = out_wait_ff;
   assign rsp_sound_on = (st_ff != 8'd0);
   assign rsp_display_cmd = out_disp_ff;
   assign rsp_error_code = out_err_ff;

   // ALU operand select: tick decrements timers, 8xyN uses the ALU group,
   // 7xkk adds immediate, compare skips use equal.
   always_comb begin
      alu_req.op = ALU_PASS_B;
      alu_req.a = vx;
      alu_req.b = vy;
      if (state_ff == ST_EXEC && op_ff == OP_TICK) begin
         alu_req.op = ALU_DEC_SAT;
         alu_req.a = dt_ff;
      end else if (state_ff == ST_TICK2) begin
         alu_req.op = ALU_DEC_SAT;
         alu_req.a = st_ff;
      end else begin
         case (w_ff[15:12])
            4'h3, 4'h4, 4'h7: alu_req.b = kk;
            default: alu_req.b = vy;
         endcase
         if (w_ff[15:12] == 4'h7) begin
            alu_req.op = ALU_ADD;
         end else if (w_ff[15:12] == 4'h8) begin
            case (n)
               4'h1: alu_req.op = ALU_OR;
               4'h2: alu_req.op = ALU_AND;
               4'h3: alu_req.op = ALU_XOR;
               4'h4: alu_req.op = ALU_ADD;
               4'h5: alu_req.op = ALU_SUB;
               4'h6: alu_req.op = ALU_SHR;
               4'h7: alu_req.op = ALU_SUBN;
               4'hE: alu_req.op = ALU_SHL;
               default: alu_req.op = ALU_PASS_B;
            endcase
         end
      end
   end

   logic key_hit;
   assign key_hit = (vx < 8'd16) && keys_ff[vx[3:0]];

   logic [11:0] pc2, pc4;
   assign pc2 = pc_ff + 12'd2;
   assign pc4 = pc_ff + 12'd4;

   logic [11:0] glyph_addr;
   assign glyph_addr = font_ff + 12'(GLYPH_BYTES * 32'(vx));

   logic [11:0] blk_addr;
   assign blk_addr = i_ff + {8'd0, cnt_ff};

   // BCD digits: hundreds by compare and subtract, tens by x*205 >> 11
   logic [1:0] bcd_hund;
   logic [7:0] bcd_rem, bcd_tens, bcd_ones;
   logic [15:0] bcd_prod;
   always_comb begin
      if (bcd_val_ff >= 8'd200) begin
         bcd_hund = 2'd2;
         bcd_rem = bcd_val_ff - 8'd200;
      end else if (bcd_val_ff >= 8'd100) begin
         bcd_hund = 2'd1;
         bcd_rem = bcd_val_ff - 8'd100;
      end else begin
         bcd_hund = 2'd0;
         bcd_rem = bcd_val_ff;
      end
      bcd_prod = {8'd0, bcd_rem} * 16'd205;
      bcd_tens = {3'd0, bcd_prod[15:11]};
      bcd_ones = bcd_rem - (bcd_tens * 8'd10);
   end

   // single write port: writes for host load, BCD and Fx55; registered read for Fx65
   logic mem_we;
   logic [11:0] mem_wa;
   logic [7:0] mem_wd;
   always_comb begin
      mem_we = 1'b0;
      mem_wa = blk_addr;
      mem_wd = v_ff[cnt_ff];
      if (state_ff == ST_EXEC && op_ff == OP_LOAD) begin
         mem_we = 1'b1;
         mem_wa = laddr_ff;
         mem_wd = ldata_ff;
      end else if (state_ff == ST_BCD) begin
         mem_we = 1'b1;
         mem_wa = i_ff + {10'd0, bcd_ff};
         case (bcd_ff)
            2'd0: mem_wd = {6'd0, bcd_hund};
            2'd1: mem_wd = bcd_tens;
            default: mem_wd = bcd_ones;
         endcase
      end else if (state_ff == ST_STORE) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_wa[MemBits-1:0]] <= mem_wd;
      end
      rdata_ff <= mem_ff[blk_addr[MemBits-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         for (int k = 0; k < 16; k++) v_ff[k] <= 8'd0;
         i_ff <= 12'd0;
         pc_ff <= 12'd512;
         font_ff <= 12'd0;
         sp_ff <= '0;
         dt_ff <= 8'd0;
         st_ff <= 8'd0;
         out_valid_ff <= 1'b0;
         out_pc_ff <= 12'd0;
         out_wait_ff <= 1'b0;
         out_disp_ff <= DISP_NONE;
         out_err_ff <= ERR_NONE;
      end else begin
         out_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (csr_valid && csr_ready) begin
                  if (csr_index == CSR_PROGRAM_START) begin
                     pc_ff <= csr_data;
                  end else begin
                     font_ff <= csr_data;
                  end
               end
               if (start) begin
                  op_ff <= req_op;
                  w_ff <= req_opcode;
                  laddr_ff <= req_load_addr;
                  ldata_ff <= req_load_data;
                  keys_ff <= req_keys_down;
                  pk_ff <= req_pressed_key;
                  rnd_ff <= req_random_byte;
                  cnt_ff <= 4'd0;
                  bcd_ff <= 2'd0;
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               // default result: no flags, and PC+2 for an executed opcode
               out_wait_ff <= 1'b0;
               out_disp_ff <= DISP_NONE;
               out_err_ff <= ERR_NONE;
               state_ff <= ST_DONE;
               if (op_ff == OP_TICK) begin
                  dt_ff <= alu_rsp.result;
                  state_ff <= ST_TICK2;
               end else if (op_ff == OP_EXEC) begin
                  pc_ff <= pc2;
                  case (w_ff[15:12])
                     4'h0: begin
                        if (w_ff == 16'h00E0) begin
                           out_disp_ff <= DISP_CLEAR;
                        end else if (w_ff == 16'h00EE) begin
                           if (sp_ff == '0) begin
                              out_err_ff <= ERR_UNDERFLOW;
                           end else begin
                              sp_ff <= sp_ff - 1'b1;
                              pc_ff <= stack_ff[SiBits'(sp_ff - 1'b1)] + 12'd2;
                           end
                        end else begin
                           out_err_ff <= ERR_UNDEFINED;
                        end
                     end
                     4'h1: pc_ff <= nnn;
                     4'h2: begin
                        if (sp_ff >= SpBits'(STACK_DEPTH)) begin
                           out_err_ff <= ERR_OVERFLOW;
                        end else begin
                           stack_ff[SiBits'(sp_ff)] <= pc_ff;
                           sp_ff <= sp_ff + 1'b1;
                           pc_ff <= nnn;
                        end
                     end
                     4'h3: if (alu_rsp.equal) pc_ff <= pc4;
                     4'h4: if (!alu_rsp.equal) pc_ff <= pc4;
                     4'h5, 4'h9: begin
                        if (n != 4'h0) begin
                           out_err_ff <= ERR_UNDEFINED;
                        end else if (alu_rsp.equal == (w_ff[15:12] == 4'h5)) begin
                           pc_ff <= pc4;
                        end
                     end
                     4'h6: v_ff[x] <= kk;
                     4'h7: v_ff[x] <= alu_rsp.result;
                     4'h8: begin
                        case (n)
                           4'h0, 4'h1, 4'h2, 4'h3: v_ff[x] <= alu_rsp.result;
                           4'h4, 4'h5, 4'h6, 4'h7, 4'hE: begin
                              // result replaces the flag when X is F
                              if (x != 4'hF) v_ff[15] <= {7'd0, alu_rsp.flag};
                              v_ff[x] <= alu_rsp.result;
                           end
                           default: out_err_ff <= ERR_UNDEFINED;
                        endcase
                     end
                     4'hA: i_ff <= nnn;
                     4'hB: pc_ff <= nnn + {4'd0, v_ff[0]};
                     4'hC: v_ff[x] <= rnd_ff & kk;
                     4'hD: out_disp_ff <= DISP_DRAW;
                     4'hE: begin
                        if (kk == 8'h9E) begin
                           if (key_hit) pc_ff <= pc4;
                        end else if (kk == 8'hA1) begin
                           if (!key_hit) pc_ff <= pc4;
                        end else begin
                           out_err_ff <= ERR_UNDEFINED;
                        end
                     end
                     default: begin
                        case (kk)
                           8'h07: v_ff[x] <= dt_ff;
                           8'h0A: begin
                              if (pk_ff > 5'd15) begin
                                 out_wait_ff <= 1'b1;
                                 pc_ff <= pc_ff;
                              end else begin
                                 v_ff[x] <= {3'd0, pk_ff};
                              end
                           end
                           8'h15: dt_ff <= vx;
                           8'h18: st_ff <= vx;
                           8'h1E: i_ff <= i_ff + {4'd0, vx};
                           8'h29: i_ff <= glyph_addr;
                           8'h33: begin
                              bcd_val_ff <= vx;
                              state_ff <= ST_BCD;
                           end
                           8'h55: state_ff <= ST_STORE;
                           8'h65: state_ff <= ST_LOAD;
                           default: out_err_ff <= ERR_UNDEFINED;
                        endcase
                     end
                  endcase
               end
            end
            ST_TICK2: begin
               st_ff <= alu_rsp.result;
               state_ff <= ST_DONE;
            end
            ST_BCD: begin
               bcd_ff <= bcd_ff + 2'd1;
               if (bcd_ff == 2'd2) state_ff <= ST_DONE;
            end
            ST_STORE: begin
               cnt_ff <= cnt_ff + 4'd1;
               if (cnt_ff == x) state_ff <= ST_DONE;
            end
            ST_LOAD: begin
               // read data is registered, so it belongs to the previous address
               if (cnt_ff != 4'd0) v_ff[cnt_ff - 4'd1] <= rdata_ff;
               if (cnt_ff == x) begin
                  state_ff <= ST_LOAD_LAST;
               end else begin
                  cnt_ff <= cnt_ff + 4'd1;
               end
            end
            ST_LOAD_LAST: begin
               v_ff[cnt_ff] <= rdata_ff;
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               out_pc_ff <= pc_ff;
               out_valid_ff <= 1'b1;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // result beat only follows the finishing state
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_DONE))
      else $error("result beat without finishing step");

   // stack level never exceeds its depth
   assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SpBits'(STACK_DEPTH))
      else $error("stack level beyond depth");

   // an accepted item always makes the unit busy next cycle
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("item accepted but unit not busy");

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the CHIP-8 instruction execute unit
// Sends opcodes, host memory loads and timer ticks through the start/busy
// port, mirrors the machine state in a bench-side predictor and compares
// every rsp_valid beat against the oldest predicted PC/status entry.
// ----------------------------------------------------------------------------
module tb_top;
   import c8x_pkg::*;

   localparam int CycleLimit = 600000;

   // one input beat, field by field
   typedef struct {
      logic [1:0]  op;
      logic [15:0] opcode;
      logic [11:0] load_addr;
      logic [7:0]  load_data;
      logic [15:0] keys_down;
      logic [4:0]  pressed_key;
      logic [7:0]  random_byte;
   } instr_beat_type;

   // one result beat
   typedef struct {
      logic [11:0] next_pc;
      logic        waiting_key;
      logic        sound_on;
      logic [1:0]  display_cmd;
      logic [1:0]  error_code;
   } status_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_op = OP_EXEC;
   logic [15:0] req_opcode = '0;
   logic [11:0] req_load_addr = '0;
   logic [7:0]  req_load_data = '0;
   logic [15:0] req_keys_down = '0;
   logic [4:0]  req_pressed_key = '0;
   logic [7:0]  req_random_byte = '0;
   logic        rsp_valid;
   logic [11:0] rsp_next_pc;
   logic        rsp_waiting_key;
   logic        rsp_sound_on;
   logic [1:0]  rsp_display_cmd;
   logic [1:0]  rsp_error_code;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [0:0]  csr_index = CSR_PROGRAM_START;
   logic [11:0] csr_data = '0;

   chip8_instruction_execute u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_opcode(req_opcode), .req_load_addr(req_load_addr),
      .req_load_data(req_load_data), .req_keys_down(req_keys_down),
      .req_pressed_key(req_pressed_key), .req_random_byte(req_random_byte),
      .rsp_valid(rsp_valid), .rsp_next_pc(rsp_next_pc),
      .rsp_waiting_key(rsp_waiting_key), .rsp_sound_on(rsp_sound_on),
      .rsp_display_cmd(rsp_display_cmd), .rsp_error_code(rsp_error_code),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Machine mirror: V registers, I, PC, return stack, timers, byte memory.
   // mem_written marks bytes that hold a defined value; never read others.
   // ------------------------------------------------------------------------
   logic [7:0]  v_reg [16];
   logic [11:0] i_reg;
   logic [11:0] pc_reg;
   logic [11:0] ret_stack [16];
   int          stack_ptr;
   logic [7:0]  delay_cnt;
   logic [7:0]  sound_cnt;
   logic [7:0]  mem_img [4096];
   bit          mem_written [4096];
   logic [11:0] start_addr_cfg;
   logic [11:0] font_base_cfg;

   status_beat_type pc_status_queue[$];
   int fail_count = 0;
   int beats_sent = 0;
   int beats_checked = 0;
   int idle_pct = 0;
   int cycle_count = 0;

   function automatic void mirror_reset();
      foreach (v_reg[k]) v_reg[k] = '0;
      foreach (mem_written[k]) mem_written[k] = 1'b0;
      i_reg = '0;
      stack_ptr = 0;
      delay_cnt = '0;
      sound_cnt = '0;
      start_addr_cfg = 12'd512;
      font_base_cfg = '0;
      pc_reg = start_addr_cfg;
   endfunction

   function automatic void mem_store(logic [11:0] addr, logic [7:0] value);
      mem_img[addr] = value;
      mem_written[addr] = 1'b1;
   endfunction

   // Advance the mirror by one beat and return the status the block must show.
   function automatic status_beat_type execute_beat(instr_beat_type b);
      status_beat_type s;
      logic [3:0]  top, x, y, n;
      logic [7:0]  kk, vx, va, vb, res;
      logic [11:0] nnn, adv;
      logic        flag, jump, alu_write;
      int          r;
      top = b.opcode[15:12];
      x = b.opcode[11:8];
      y = b.opcode[7:4];
      n = b.opcode[3:0];
      kk = b.opcode[7:0];
      nnn = b.opcode[11:0];
      vx = v_reg[x];
      adv = 12'd2;
      jump = 1'b0;
      s.waiting_key = 1'b0;
      s.display_cmd = DISP_NONE;
      s.error_code = ERR_NONE;
      if (b.op == OP_LOAD) begin
         mem_store(b.load_addr, b.load_data);
      end else if (b.op == OP_TICK) begin
         if (delay_cnt != 0) delay_cnt--;
         if (sound_cnt != 0) sound_cnt--;
      end else if (b.op == OP_EXEC) begin
         case (top)
            4'h0: begin
               if (b.opcode == 16'h00E0) s.display_cmd = DISP_CLEAR;
               else if (b.opcode == 16'h00EE) begin
                  if (stack_ptr == 0) s.error_code = ERR_UNDERFLOW;
                  else begin
                     stack_ptr--;
                     pc_reg = ret_stack[stack_ptr];
                  end
               end else s.error_code = ERR_UNDEFINED;
            end
            4'h1: begin
               pc_reg = nnn;
               jump = 1'b1;
            end
            4'h2: begin
               if (stack_ptr >= 16) s.error_code = ERR_OVERFLOW;
               else begin
                  ret_stack[stack_ptr] = pc_reg;
                  stack_ptr++;
                  pc_reg = nnn;
                  jump = 1'b1;
               end
            end
            4'h3: if (vx == kk) adv = 12'd4;
            4'h4: if (vx != kk) adv = 12'd4;
            4'h5: begin
               if (n != 0) s.error_code = ERR_UNDEFINED;
               else if (vx == v_reg[y]) adv = 12'd4;
            end
            4'h6: v_reg[x] = kk;
            4'h7: v_reg[x] = vx + kk;
            4'h8: begin
               // read both operands before any write; X == F lets the result win
               va = v_reg[x];
               vb = v_reg[y];
               alu_write = 1'b1;
               flag = 1'b0;
               res = '0;
               case (n)
                  4'h0: begin res = vb; alu_write = 1'b0; v_reg[x] = vb; end
                  4'h1: begin alu_write = 1'b0; v_reg[x] = va | vb; end
                  4'h2: begin alu_write = 1'b0; v_reg[x] = va & vb; end
                  4'h3: begin alu_write = 1'b0; v_reg[x] = va ^ vb; end
                  4'h4: begin
                     r = int'(va) + int'(vb);
                     res = r[7:0];
                     flag = (r > 255);
                  end
                  4'h5: begin res = va - vb; flag = (va >= vb); end
                  4'h6: begin res = va >> 1; flag = va[0]; end
                  4'h7: begin res = vb - va; flag = (vb >= va); end
                  4'hE: begin res = va << 1; flag = va[7]; end
                  default: begin
                     alu_write = 1'b0;
                     s.error_code = ERR_UNDEFINED;
                  end
               endcase
               if (alu_write) begin
                  v_reg[15] = {7'd0, flag};
                  v_reg[x] = res;
               end
            end
            4'h9: begin
               if (n != 0) s.error_code = ERR_UNDEFINED;
               else if (vx != v_reg[y]) adv = 12'd4;
            end
            4'hA: i_reg = nnn;
            4'hB: begin
               pc_reg = nnn + {4'd0, v_reg[0]};
               jump = 1'b1;
            end
            4'hC: v_reg[x] = b.random_byte & kk;
            4'hD: s.display_cmd = DISP_DRAW;
            4'hE: begin
               if (kk == 8'h9E) begin
                  if (vx < 16 && b.keys_down[vx[3:0]]) adv = 12'd4;
               end else if (kk == 8'hA1) begin
                  if (!(vx < 16 && b.keys_down[vx[3:0]])) adv = 12'd4;
               end else s.error_code = ERR_UNDEFINED;
            end
            default: begin
               case (kk)
                  8'h07: v_reg[x] = delay_cnt;
                  8'h0A: begin
                     if (b.pressed_key > 15) begin
                        s.waiting_key = 1'b1;
                        adv = '0;
                     end else v_reg[x] = {3'd0, b.pressed_key};
                  end
                  8'h15: delay_cnt = vx;
                  8'h18: sound_cnt = vx;
                  8'h1E: i_reg = i_reg + {4'd0, vx};
                  8'h29: i_reg = font_base_cfg + 12'(5 * int'(vx));
                  8'h33: begin
                     mem_store(i_reg, 8'(vx / 8'd100));
                     mem_store(i_reg + 12'd1, 8'((vx / 8'd10) % 8'd10));
                     mem_store(i_reg + 12'd2, 8'(vx % 8'd10));
                  end
                  8'h55: for (int k = 0; k <= x; k++) mem_store(i_reg + 12'(k), v_reg[k]);
                  8'h65: for (int k = 0; k <= x; k++) v_reg[k] = mem_img[i_reg + 12'(k)];
                  default: s.error_code = ERR_UNDEFINED;
               endcase
            end
         endcase
         if (!jump) pc_reg = pc_reg + adv;
      end
      s.next_pc = pc_reg;
      s.sound_on = (sound_cnt != 0);
      return s;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus plumbing
   // ------------------------------------------------------------------------
   // Drive one beat at the falling edge and hold it until start && !busy is
   // seen at a rising edge; predict on acceptance.
   task automatic send_beat(instr_beat_type b);
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
         repeat ($urandom_range(0, 5)) @(negedge clock);
      end
      @(negedge clock);
      start <= 1'b1;
      req_op <= b.op;
      req_opcode <= b.opcode;
      req_load_addr <= b.load_addr;
      req_load_data <= b.load_data;
      req_keys_down <= b.keys_down;
      req_pressed_key <= b.pressed_key;
      req_random_byte <= b.random_byte;
      do @(posedge clock); while (busy);
      pc_status_queue.push_back(execute_beat(b));
      beats_sent++;
   endtask

   function automatic instr_beat_type exec_beat(logic [15:0] opcode);
      instr_beat_type b;
      b.op = OP_EXEC;
      b.opcode = opcode;
      b.load_addr = 12'($urandom);
      b.load_data = 8'($urandom);
      b.keys_down = 16'($urandom);
      b.pressed_key = 5'($urandom_range(0, 31));
      b.random_byte = 8'($urandom);
      return b;
   endfunction

   function automatic instr_beat_type load_beat(logic [11:0] addr, logic [7:0] data);
      instr_beat_type b;
      b = exec_beat(16'($urandom));
      b.op = OP_LOAD;
      b.load_addr = addr;
      b.load_data = data;
      return b;
   endfunction

   // Drop start and wait until every predicted beat has come back.
   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (pc_status_queue.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Write a register with the block idle.
   task automatic write_csr(logic [0:0] idx, logic [11:0] value);
      drain_results();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_PROGRAM_START) begin
         start_addr_cfg = value;
         pc_reg = value;
      end else font_base_cfg = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Pick an instruction; block loads only read bytes that hold data.
   function automatic logic [15:0] pick_opcode();
      logic [15:0] w;
      int sel, span;
      w = 16'($urandom);
      sel = $urandom_range(0, 29);
      case (sel)
         0: w = ($urandom_range(0, 1) != 0) ? 16'h00E0 : 16'h00EE;
         1, 2: w = 16'h00EE;
         3, 4: w[15:12] = 4'h2;
         5: w[15:12] = 4'h1;
         6: w[15:12] = 4'hB;
         7, 8: w[15:12] = 4'h8;
         9: begin w[15:12] = 4'h8; w[3:0] = 4'($urandom_range(4, 7)); end
         10: begin w[15:12] = 4'h8; w[11:8] = 4'hF; end
         11, 12: w[15:12] = 4'h6;
         13: w[15:12] = 4'h7;
         14: w[15:12] = 4'($urandom_range(3, 4));
         15: begin w[15:12] = 4'h5; w[3:0] = ($urandom_range(0, 3) != 0) ? 4'h0 : w[3:0]; end
         16: begin w[15:12] = 4'h9; w[3:0] = ($urandom_range(0, 3) != 0) ? 4'h0 : w[3:0]; end
         17: w[15:12] = 4'hA;
         18: w[15:12] = 4'hC;
         19: w[15:12] = 4'hD;
         20: begin
            w[15:12] = 4'hE;
            if ($urandom_range(0, 4) != 0) w[7:0] = ($urandom_range(0, 1) != 0) ? 8'h9E : 8'hA1;
         end
         21: begin
            w[15:12] = 4'hF;
            case ($urandom_range(0, 6))
               0: w[7:0] = 8'h07;
               1: w[7:0] = 8'h0A;
               2: w[7:0] = 8'h15;
               3: w[7:0] = 8'h18;
               4: w[7:0] = 8'h1E;
               5: w[7:0] = 8'h29;
               default: w[7:0] = w[7:0];
            endcase
         end
         22, 23: begin w[15:12] = 4'hF; w[7:0] = 8'h33; end
         24, 25: begin w[15:12] = 4'hF; w[7:0] = 8'h55; end
         26, 27, 28: begin w[15:12] = 4'hF; w[7:0] = 8'h65; end
         default: w = w;
      endcase
      // a block load must only touch bytes that were written
      if (w[15:12] == 4'hF && w[7:0] == 8'h65) begin
         span = 0;
         while (span < 16 && mem_written[i_reg + 12'(span)]) span++;
         if (span == 0) w[7:0] = 8'h55;
         else w[11:8] = 4'($urandom_range(0, span - 1));
      end
      return w;
   endfunction

   // ------------------------------------------------------------------------
   // Result checker: every rsp_valid beat must match the oldest prediction.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      status_beat_type e;
      if (!reset && rsp_valid) begin
         if (pc_status_queue.size() == 0) begin
            $error("unexpected result beat, next_pc %0h", rsp_next_pc);
            fail_count++;
         end else begin
            e = pc_status_queue.pop_front();
            beats_checked++;
            if (rsp_next_pc !== e.next_pc) begin
               $error("next_pc: expected %0h actual %0h", e.next_pc, rsp_next_pc);
               fail_count++;
            end
            if (rsp_waiting_key !== e.waiting_key) begin
               $error("waiting_key: expected %0d actual %0d", e.waiting_key,
                      rsp_waiting_key);
               fail_count++;
            end
            if (rsp_sound_on !== e.sound_on) begin
               $error("sound_on: expected %0d actual %0d", e.sound_on, rsp_sound_on);
               fail_count++;
            end
            if (rsp_display_cmd !== e.display_cmd) begin
               $error("display_cmd: expected %0d actual %0d", e.display_cmd,
                      rsp_display_cmd);
               fail_count++;
            end
            if (rsp_error_code !== e.error_code) begin
               $error("error_code: expected %0d actual %0d", e.error_code,
                      rsp_error_code);
               fail_count++;
            end
         end
      end
   end

   // Hard stop if the block hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // Field extremes, host loads, ticks, groups 0, 6, 8, A, B, D, E, F and corner cases.
   task automatic test_directed();
      instr_beat_type b;
      idle_pct = 0;
      send_beat(load_beat(12'hFFF, 8'hFF));      // top of memory
      send_beat(load_beat(12'h000, 8'h00));
      send_beat(exec_beat(16'h60FF));            // V0 = FF
      send_beat(exec_beat(16'h6101));
      send_beat(exec_beat(16'h8014));            // add with carry out
      send_beat(exec_beat(16'h8105));            // V1 above V0: no borrow
      send_beat(exec_beat(16'h6FF0));
      send_beat(exec_beat(16'h8F1E));            // X == F: result wins over flag
      send_beat(exec_beat(16'h8F17));
      send_beat(exec_beat(16'h8108));            // undefined ALU op
      send_beat(exec_beat(16'h00E0));
      send_beat(exec_beat(16'hD125));
      send_beat(exec_beat(16'h00EE));            // return on empty stack
      send_beat(exec_beat(16'h0123));            // undefined 0nnn
      b = exec_beat(16'hF20A);                   // key wait, nothing pressed
      b.pressed_key = 5'd16;
      send_beat(b);
      send_beat(exec_beat(16'h62FF));
      send_beat(exec_beat(16'hF229));            // font address with full Vx
      send_beat(exec_beat(16'hAFFE));
      send_beat(exec_beat(16'hF233));            // BCD across the wrap
      send_beat(exec_beat(16'hF265));
      send_beat(exec_beat(16'hF218));
      b = exec_beat(16'h0000);
      b.op = OP_TICK;
      send_beat(b);
      b.op = 2'd3;                               // unused op code
      send_beat(b);
      send_beat(exec_beat(16'hE29E));            // key number above 15
      send_beat(exec_beat(16'hBFFF));            // jump with wrap
   endtask

   // Fill the return stack past its depth, then unwind past empty.
   task automatic test_stack();
      idle_pct = 65;
      repeat (17) send_beat(exec_beat({4'h2, 12'($urandom)}));
      repeat (17) send_beat(exec_beat(16'h00EE));
   endtask

   // Mostly well-formed instruction streams with host loads and ticks mixed in.
   task automatic test_random(int count, int idle);
      instr_beat_type b;
      int sel;
      idle_pct = idle;
      for (int k = 0; k < count; k++) begin
         sel = $urandom_range(0, 99);
         if (sel < 10) b = load_beat(12'($urandom), 8'($urandom));
         else if (sel < 14) begin
            b = exec_beat(16'($urandom));
            b.op = OP_TICK;
         end else if (sel < 15) begin
            b = exec_beat(16'($urandom));
            b.op = 2'd3;
         end else b = exec_beat(pick_opcode());
         send_beat(b);
         if (k == count / 2) drain_results();   // sender holds off until drained
      end
   endtask

   initial begin
      mirror_reset();
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_stack();
      write_csr(CSR_PROGRAM_START, 12'h000);
      write_csr(CSR_FONT_BASE, 12'hFFF);
      test_random(450, 0);
      write_csr(CSR_PROGRAM_START, 12'hFFF);
      write_csr(CSR_FONT_BASE, 12'h000);
      test_random(450, 65);
      write_csr(CSR_PROGRAM_START, 12'h3A6);
      write_csr(CSR_FONT_BASE, 12'h0A5);
      test_random(450, 34);
      write_csr(CSR_PROGRAM_START, 12'd512);
      write_csr(CSR_FONT_BASE, 12'h050);
      test_random(450, 65);
      drain_results();
      $display("Covered %0d beats (%0d results checked) over directed, stack and",
               beats_sent, beats_checked);
      $display("four random phases with csr extremes and sender gaps.");
      if (fail_count == 0 && pc_status_queue.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/core/c8x_pkg.sv
rtl/core/c8x_alu.sv
rtl/core/chip8_instruction_execute.sv
tb/sv/tb_top.sv
